// ----- src/tep_pkg.sv -----
// Shared codes, sizes and control types for the tiered eviction planner.
package tep_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VRAM_CAPACITY  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VRAM_HELD_BACK = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VRAM_IN_USE    = 2'd2;

    // Result queue geometry.
    localparam int RESULT_FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS     = 2;
    localparam int FIFO_COUNT_BITS   = 3;

    typedef enum logic [1:0] {
        KIND_DECISION     = 2'd0,
        KIND_SATISFIED    = 2'd1,
        KIND_BUDGET_ERROR = 2'd2
    } result_kind_t;

    typedef enum logic {
        TIER_HOST = 1'b0,
        TIER_NVME = 1'b1
    } tier_t;

    typedef enum logic [1:0] {
        REASON_DEMOTE     = 2'd0,
        REASON_WRITEBACK  = 2'd1,
        REASON_CLEAN_DROP = 2'd2,
        REASON_SPILL      = 2'd3
    } reason_t;

    // Queue push request: second is only set together with first.
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// ----- src/tep_if.sv -----
// Valid/ready channel interfaces for planner input items and result words.
interface tep_in_if #(
    parameter int BYTE_COUNT_BITS = 48,
    parameter int PAGE_ID_BITS    = 32
);
    logic                       valid;
    logic                       ready;
    logic                       plan_start;
    logic [BYTE_COUNT_BITS-1:0] request_bytes;
    logic [BYTE_COUNT_BITS-1:0] host_avail_bytes;
    logic                       page_present;
    logic [PAGE_ID_BITS-1:0]    page_ident;
    logic [BYTE_COUNT_BITS-1:0] page_bytes;
    logic                       page_pinned;
    logic                       page_busy;
    logic                       page_dirty;
    logic                       page_on_nvme;
    logic                       plan_end;

    modport source (
        output valid, plan_start, request_bytes, host_avail_bytes, page_present,
               page_ident, page_bytes, page_pinned, page_busy, page_dirty,
               page_on_nvme, plan_end,
        input  ready
    );

    modport sink (
        input  valid, plan_start, request_bytes, host_avail_bytes, page_present,
               page_ident, page_bytes, page_pinned, page_busy, page_dirty,
               page_on_nvme, plan_end,
        output ready
    );
endinterface

interface tep_out_if #(
    parameter int BYTE_COUNT_BITS = 48,
    parameter int PAGE_ID_BITS    = 32
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 result_kind;
    logic [PAGE_ID_BITS-1:0]    victim_ident;
    logic                       target_tier;
    logic [1:0]                 reason_code;
    logic [BYTE_COUNT_BITS-1:0] shortfall_bytes;
    logic                       run_end;

    modport source (
        output valid, result_kind, victim_ident, target_tier, reason_code,
               shortfall_bytes, run_end,
        input  ready
    );

    modport sink (
        input  valid, result_kind, victim_ident, target_tier, reason_code,
               shortfall_bytes, run_end,
        output ready
    );
endinterface

// ----- src/tep_budget_cfg.sv -----
// Configuration registers and the registered VRAM headroom derived from them.
module tep_budget_cfg #(
    parameter int BYTE_COUNT_BITS = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [BYTE_COUNT_BITS-1:0]       cfg_data,
    output logic [BYTE_COUNT_BITS-1:0]       headroom
);
    import tep_pkg::*;

    logic [BYTE_COUNT_BITS-1:0] capacity_reg, capacity_next;
    logic [BYTE_COUNT_BITS-1:0] held_back_reg, held_back_next;
    logic [BYTE_COUNT_BITS-1:0] in_use_reg, in_use_next;
    logic [BYTE_COUNT_BITS-1:0] headroom_reg, headroom_next;
    logic [BYTE_COUNT_BITS:0]   usable_diff;
    logic [BYTE_COUNT_BITS-1:0] usable;
    logic [BYTE_COUNT_BITS:0]   room_diff;

    always_comb
    begin
        capacity_next  = capacity_reg;
        held_back_next = held_back_reg;
        in_use_next    = in_use_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VRAM_CAPACITY:  capacity_next  = cfg_data;
                CFG_VRAM_HELD_BACK: held_back_next = cfg_data;
                CFG_VRAM_IN_USE:    in_use_next    = cfg_data;
                default:            ;
            endcase
        end
    end

    // Floor each difference at zero; work from the next values so the
    // headroom is current at the same edge as the write.
    always_comb
    begin
        usable_diff   = {1'b0, capacity_next} - {1'b0, held_back_next};
        usable        = usable_diff[BYTE_COUNT_BITS] ? '0 : usable_diff[BYTE_COUNT_BITS-1:0];
        room_diff     = {1'b0, usable} - {1'b0, in_use_next};
        headroom_next = room_diff[BYTE_COUNT_BITS] ? '0 : room_diff[BYTE_COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            held_back_reg <= '0;
            in_use_reg    <= '0;
            headroom_reg  <= '0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            held_back_reg <= held_back_next;
            in_use_reg    <= in_use_next;
            headroom_reg  <= headroom_next;
        end
    end

    assign headroom = headroom_reg;

endmodule

// ----- src/tep_result_fifo.sv -----
// Small result queue: pushes up to two words a cycle, pops one.
module tep_result_fifo #(
    parameter int DATA_W = 86
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tep_pkg::push_t      push,
    input  logic [DATA_W-1:0]   wr_first,
    input  logic [DATA_W-1:0]   wr_second,
    output logic                room_for_two,
    output logic                rd_valid,
    input  logic                rd_ready,
    output logic [DATA_W-1:0]   rd_data
);
    import tep_pkg::*;

    logic [DATA_W-1:0]          mem_reg [RESULT_FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_COUNT_BITS-1:0] count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_plus1;
    logic                       pop;

    assign pop          = rd_valid && rd_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.first) + FIFO_PTR_BITS'(push.second);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_COUNT_BITS'(push.first)
                    + FIFO_COUNT_BITS'(push.second) - FIFO_COUNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_ptr_reg] <= wr_first;
        end
        if (push.second)
        begin
            mem_reg[wr_ptr_plus1] <= wr_second;
        end
    end

    assign room_for_two = count_reg <= FIFO_COUNT_BITS'(RESULT_FIFO_DEPTH - 2);
    assign rd_valid     = count_reg != '0;
    assign rd_data      = mem_reg[rd_ptr_reg];

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_COUNT_BITS'(RESULT_FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second word pushed without first");

endmodule

// ----- src/tep_plan_core.sv -----
// Input register, plan state and the single-pass eviction decision.
module tep_plan_core #(
    parameter int BYTE_COUNT_BITS = 48,
    parameter int PAGE_ID_BITS    = 32,
    localparam int RESULT_W       = 2 + PAGE_ID_BITS + 1 + 2 + BYTE_COUNT_BITS + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tep_in_if.sink                     in_ch,
    input  logic [BYTE_COUNT_BITS-1:0] headroom,
    input  logic                       room_for_two,
    output tep_pkg::push_t             push,
    output logic [RESULT_W-1:0]        entry_first,
    output logic [RESULT_W-1:0]        entry_second
);
    import tep_pkg::*;

    typedef struct packed {
        logic                       plan_start;
        logic [BYTE_COUNT_BITS-1:0] request_bytes;
        logic [BYTE_COUNT_BITS-1:0] host_avail_bytes;
        logic                       page_present;
        logic [PAGE_ID_BITS-1:0]    page_ident;
        logic [BYTE_COUNT_BITS-1:0] page_bytes;
        logic                       page_pinned;
        logic                       page_busy;
        logic                       page_dirty;
        logic                       page_on_nvme;
        logic                       plan_end;
    } item_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [PAGE_ID_BITS-1:0]    ident;
        logic                       tier;
        logic [1:0]                 reason;
        logic [BYTE_COUNT_BITS-1:0] shortfall;
        logic                       run_end;
    } result_t;

    item_t                      item_reg;
    logic                       item_valid_reg, item_valid_next;
    logic [BYTE_COUNT_BITS-1:0] needed_reg, needed_next;
    logic [BYTE_COUNT_BITS-1:0] host_reg, host_next;

    logic                       accept;
    logic                       fire;
    logic [BYTE_COUNT_BITS:0]   start_diff;
    logic [BYTE_COUNT_BITS-1:0] need_cur;
    logic [BYTE_COUNT_BITS-1:0] host_cur;
    logic [BYTE_COUNT_BITS:0]   host_diff;
    logic [BYTE_COUNT_BITS:0]   need_diff;
    logic [BYTE_COUNT_BITS-1:0] need_after;
    logic [BYTE_COUNT_BITS-1:0] host_after;
    logic                       decide;
    logic                       to_nvme;
    reason_t                    reason;
    result_t                    decision;
    result_t                    status;

    assign accept      = in_ch.valid && in_ch.ready;
    assign fire        = item_valid_reg && room_for_two;
    assign in_ch.ready = !item_valid_reg || room_for_two;

    always_comb
    begin
        // Plan start first: shortfall is the request beyond headroom.
        start_diff = {1'b0, item_reg.request_bytes} - {1'b0, headroom};
        if (item_reg.plan_start)
        begin
            need_cur = start_diff[BYTE_COUNT_BITS] ? '0 : start_diff[BYTE_COUNT_BITS-1:0];
            host_cur = item_reg.host_avail_bytes;
        end
        else
        begin
            need_cur = needed_reg;
            host_cur = host_reg;
        end

        // Then the page: skip pinned or busy pages and met plans.
        decide = item_reg.page_present && (need_cur != '0)
              && !item_reg.page_pinned && !item_reg.page_busy;
        host_diff = {1'b0, host_cur} - {1'b0, item_reg.page_bytes};
        to_nvme   = host_diff[BYTE_COUNT_BITS];
        need_diff = {1'b0, need_cur} - {1'b0, item_reg.page_bytes};

        need_after = need_cur;
        host_after = host_cur;
        if (decide)
        begin
            need_after = need_diff[BYTE_COUNT_BITS] ? '0 : need_diff[BYTE_COUNT_BITS-1:0];
            if (!to_nvme)
            begin
                host_after = host_diff[BYTE_COUNT_BITS-1:0];
            end
        end

        priority if (!to_nvme)
            reason = REASON_DEMOTE;
        else if (item_reg.page_dirty)
            reason = REASON_WRITEBACK;
        else if (item_reg.page_on_nvme)
            reason = REASON_CLEAN_DROP;
        else
            reason = REASON_SPILL;
    end

    always_comb
    begin
        decision.kind      = KIND_DECISION;
        decision.ident     = item_reg.page_ident;
        decision.tier      = to_nvme ? TIER_NVME : TIER_HOST;
        decision.reason    = reason;
        decision.shortfall = need_after;
        decision.run_end   = !item_reg.plan_end;

        status.kind      = (need_after == '0) ? KIND_SATISFIED : KIND_BUDGET_ERROR;
        status.ident     = '0;
        status.tier      = TIER_HOST;
        status.reason    = REASON_DEMOTE;
        status.shortfall = need_after;
        status.run_end   = 1'b1;

        entry_first  = decide ? decision : status;
        entry_second = status;

        push.first  = fire && (decide || item_reg.plan_end);
        push.second = fire && decide && item_reg.plan_end;
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;

        needed_next = fire ? need_after : needed_reg;
        host_next   = fire ? host_after : host_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            needed_reg     <= '0;
            host_reg       <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            needed_reg     <= needed_next;
            host_reg       <= host_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.plan_start       <= in_ch.plan_start;
            item_reg.request_bytes    <= in_ch.request_bytes;
            item_reg.host_avail_bytes <= in_ch.host_avail_bytes;
            item_reg.page_present     <= in_ch.page_present;
            item_reg.page_ident       <= in_ch.page_ident;
            item_reg.page_bytes       <= in_ch.page_bytes;
            item_reg.page_pinned      <= in_ch.page_pinned;
            item_reg.page_busy        <= in_ch.page_busy;
            item_reg.page_dirty       <= in_ch.page_dirty;
            item_reg.page_on_nvme     <= in_ch.page_on_nvme;
            item_reg.plan_end         <= in_ch.plan_end;
        end
    end

    a_need_only_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item_reg.plan_start |=> needed_reg <= $past(needed_reg))
        else $error("shortfall grew inside a plan");

    a_host_only_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item_reg.plan_start |=> host_reg <= $past(host_reg))
        else $error("host budget grew inside a plan");

    a_hold_without_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !room_for_two |=> item_valid_reg && $stable(needed_reg))
        else $error("item lost while result queue was full");

endmodule

// ----- src/tiered_eviction_planner.sv -----
// Top level of the tiered eviction planner: config port, plan core, result queue.
//
// The planner takes one item per cycle while the result queue has room. An item is
// held in an input register, where a single pass of compares and subtractions
// against the running shortfall and host budget decides it, and its zero, one or
// two result words go into a four-word result queue; the first result word becomes
// valid once it has been written into the queue from the input register. The single
// output port drains one word per cycle while the consumer is ready, so items that
// give at most one result flow at one per cycle, and an item that gives a decision
// plus a plan status costs two output words. The input register stalls only when
// the queue has fewer than two free words. Configuration writes are registered, and
// the headroom they imply is registered at the same edge.
module tiered_eviction_planner #(
    parameter int BYTE_COUNT_BITS = 48,
    parameter int PAGE_ID_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [BYTE_COUNT_BITS-1:0]         cfg_data,
    tep_in_if.sink                             in_ch,
    tep_out_if.source                          out_ch
);
    import tep_pkg::*;

    localparam int RESULT_W = 2 + PAGE_ID_BITS + 1 + 2 + BYTE_COUNT_BITS + 1;

    logic [BYTE_COUNT_BITS-1:0] headroom;
    logic                       room_for_two;
    push_t                      push;
    logic [RESULT_W-1:0]        entry_first;
    logic [RESULT_W-1:0]        entry_second;
    logic [RESULT_W-1:0]        head_word;

    // Hold the VRAM limits and precompute the headroom a new plan starts from.
    tep_budget_cfg #(
        .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
    ) u_budget_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .headroom  (headroom)
    );

    // Register the item, update shortfall and host budget, build result words.
    tep_plan_core #(
        .BYTE_COUNT_BITS (BYTE_COUNT_BITS),
        .PAGE_ID_BITS    (PAGE_ID_BITS)
    ) u_plan_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .headroom     (headroom),
        .room_for_two (room_for_two),
        .push         (push),
        .entry_first  (entry_first),
        .entry_second (entry_second)
    );

    // Queue results so the core keeps moving while the consumer stalls.
    tep_result_fifo #(
        .DATA_W (RESULT_W)
    ) u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .wr_first     (entry_first),
        .wr_second    (entry_second),
        .room_for_two (room_for_two),
        .rd_valid     (out_ch.valid),
        .rd_ready     (out_ch.ready),
        .rd_data      (head_word)
    );

    // Unpack the head word in the core's field order.
    assign {out_ch.result_kind, out_ch.victim_ident, out_ch.target_tier,
            out_ch.reason_code, out_ch.shortfall_bytes, out_ch.run_end} = head_word;

endmodule

// ----- bench/tep_plan_checker.sv -----
// Port monitor for the tiered eviction planner: predicts each result word and compares it.
`timescale 1ns / 1ps
module tep_plan_checker #(
    parameter int BYTE_COUNT_BITS = 48,
    parameter int PAGE_ID_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [BYTE_COUNT_BITS-1:0]         cfg_data,
    tep_in_if                                  in_mon,
    tep_out_if                                 out_mon,
    output int                                 mismatches,
    output int                                 words_pending
);
    import tep_pkg::*;

    typedef logic [BYTE_COUNT_BITS-1:0] bytes_t;

    typedef struct {
        result_kind_t            kind;
        logic [PAGE_ID_BITS-1:0] victim;
        tier_t                   tier;
        reason_t                 reason;
        bytes_t                  shortfall;
        logic                    run_end;
    } plan_result_t;

    bytes_t       capacity_bytes;
    bytes_t       held_back_bytes;
    bytes_t       in_use_bytes;
    bytes_t       need_left;
    bytes_t       host_left;
    int           fail_tally = 0;
    plan_result_t expected_results[$];

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        plan_result_t want;
        plan_result_t decision;
        plan_result_t status;
        bytes_t       usable;
        bytes_t       headroom;
        bytes_t       freed;
        if (!rst_n)
        begin
            capacity_bytes  = '0;
            held_back_bytes = '0;
            in_use_bytes    = '0;
            need_left       = '0;
            host_left       = '0;
            expected_results.delete();
            words_pending <= 0;
            mismatches    <= fail_tally;
        end
        else
        begin
            // Result side: match against the oldest outstanding word.
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with none expected: kind %0d victim %0h shortfall %0d",
                           out_mon.result_kind, out_mon.victim_ident, out_mon.shortfall_bytes);
                    fail_tally++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_mon.result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d",
                               want.kind, out_mon.result_kind);
                        fail_tally++;
                    end
                    if (out_mon.victim_ident !== want.victim)
                    begin
                        $error("victim_ident: expected %0h, got %0h",
                               want.victim, out_mon.victim_ident);
                        fail_tally++;
                    end
                    if (out_mon.target_tier !== want.tier)
                    begin
                        $error("target_tier: expected %0d, got %0d",
                               want.tier, out_mon.target_tier);
                        fail_tally++;
                    end
                    if (out_mon.reason_code !== want.reason)
                    begin
                        $error("reason_code: expected %0d, got %0d",
                               want.reason, out_mon.reason_code);
                        fail_tally++;
                    end
                    if (out_mon.shortfall_bytes !== want.shortfall)
                    begin
                        $error("shortfall_bytes: expected %0d, got %0d",
                               want.shortfall, out_mon.shortfall_bytes);
                        fail_tally++;
                    end
                    if (out_mon.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d",
                               want.run_end, out_mon.run_end);
                        fail_tally++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VRAM_CAPACITY:  capacity_bytes  = cfg_data;
                    CFG_VRAM_HELD_BACK: held_back_bytes = cfg_data;
                    CFG_VRAM_IN_USE:    in_use_bytes    = cfg_data;
                    default: ;
                endcase
            end

            // Input side: plan start, then the page, then the plan end.
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.plan_start)
                begin
                    usable    = (capacity_bytes >= held_back_bytes) ?
                                capacity_bytes - held_back_bytes : '0;
                    headroom  = (in_use_bytes < usable) ? usable - in_use_bytes : '0;
                    need_left = (in_mon.request_bytes > headroom) ?
                                in_mon.request_bytes - headroom : '0;
                    host_left = in_mon.host_avail_bytes;
                end

                if (in_mon.page_present && need_left != '0 &&
                    !in_mon.page_pinned && !in_mon.page_busy)
                begin
                    decision.kind   = KIND_DECISION;
                    decision.victim = in_mon.page_ident;
                    if (host_left < in_mon.page_bytes)
                    begin
                        decision.tier   = TIER_NVME;
                        decision.reason = in_mon.page_dirty ? REASON_WRITEBACK :
                                          (in_mon.page_on_nvme ? REASON_CLEAN_DROP :
                                                                 REASON_SPILL);
                    end
                    else
                    begin
                        decision.tier   = TIER_HOST;
                        decision.reason = REASON_DEMOTE;
                        host_left       = host_left - in_mon.page_bytes;
                    end
                    freed = (in_mon.page_bytes < need_left) ? in_mon.page_bytes : need_left;
                    need_left          = need_left - freed;
                    decision.shortfall = need_left;
                    decision.run_end   = !in_mon.plan_end;
                    expected_results.insert(expected_results.size(), decision);
                end

                if (in_mon.plan_end)
                begin
                    status.kind      = (need_left == '0) ? KIND_SATISFIED : KIND_BUDGET_ERROR;
                    status.victim    = '0;
                    status.tier      = TIER_HOST;
                    status.reason    = REASON_DEMOTE;
                    status.shortfall = need_left;
                    status.run_end   = 1'b1;
                    expected_results.insert(expected_results.size(), status);
                end
            end

            words_pending <= expected_results.size();
            mismatches    <= fail_tally;
        end
    end

endmodule

// ----- bench/tb_tiered_eviction_planner.sv -----
// Testbench top for the tiered eviction planner: clock, reset, register writes, stimulus, verdict.
`timescale 1ns / 1ps
module tb_tiered_eviction_planner;
    import tep_pkg::*;

    localparam int BYTE_COUNT_BITS = 48;
    localparam int PAGE_ID_BITS    = 32;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 175;
    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int IDLE_LIMIT      = 2000;
    // Covers the input register and the result queue, with slack after that.
    localparam int DRAIN_CYCLES    = 8;

    // Page attribute flags, packed as {pinned, busy, dirty, on_nvme}.
    localparam logic [3:0] PG_NONE    = 4'b0000;
    localparam logic [3:0] PG_PINNED  = 4'b1000;
    localparam logic [3:0] PG_BUSY    = 4'b0100;
    localparam logic [3:0] PG_DIRTY   = 4'b0010;
    localparam logic [3:0] PG_ON_NVME = 4'b0001;

    // The one index the register port decodes to nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    typedef logic [BYTE_COUNT_BITS-1:0] bytes_t;
    typedef logic [PAGE_ID_BITS-1:0]    page_id_t;

    localparam bytes_t   BYTES_MAX = '1;
    localparam page_id_t IDENT_MAX = '1;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    bytes_t                    cfg_data;
    int                        failures;
    int                        words_pending;
    int                        words_sent = 0;
    int                        burst_left = 0;
    int                        idle_cycles = 0;

    tep_in_if #(
        .BYTE_COUNT_BITS(BYTE_COUNT_BITS),
        .PAGE_ID_BITS   (PAGE_ID_BITS)
    ) in_ch ();

    tep_out_if #(
        .BYTE_COUNT_BITS(BYTE_COUNT_BITS),
        .PAGE_ID_BITS   (PAGE_ID_BITS)
    ) out_ch ();

    tiered_eviction_planner #(
        .BYTE_COUNT_BITS(BYTE_COUNT_BITS),
        .PAGE_ID_BITS   (PAGE_ID_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    tep_plan_checker #(
        .BYTE_COUNT_BITS(BYTE_COUNT_BITS),
        .PAGE_ID_BITS   (PAGE_ID_BITS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .mismatches   (failures),
        .words_pending(words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hang detection: count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side back-pressure: rotate an 8-bit ready mask, reloading it with a new random value.
    // About one reload in four is all ones, which gives stretches with no stalls at all.
    // Bit 0 is forced high so every reloaded mask holds at least one ready bit.
    initial
    begin : result_pacing
        logic [7:0] ready_mask;
        int         tick;
        out_ch.ready = 1'b0;
        ready_mask   = 8'hFF;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            if (tick % 32 == 0)
                ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            ready_mask   = {ready_mask[0], ready_mask[7:1]};
            out_ch.ready <= ready_mask[0];
            tick++;
        end
    end

    // Random byte count below 2**bits, with the field's zero and top value mixed in.
    function automatic bytes_t rand_bytes(int bits);
        bytes_t field_mask;
        bytes_t value;
        field_mask = (bits >= BYTE_COUNT_BITS) ? BYTES_MAX : ((bytes_t'(1) << bits) - 1);
        value      = bytes_t'({$urandom, $urandom});
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return field_mask;
            default: return value & field_mask;
        endcase
    endfunction

    // Mostly movable pages; pinned and busy each about one in eight.
    function automatic logic [3:0] rand_page_flags();
        logic [3:0] flags;
        flags = PG_NONE;
        if ($urandom_range(0, 7) == 0)
            flags = flags | PG_PINNED;
        if ($urandom_range(0, 7) == 0)
            flags = flags | PG_BUSY;
        if ($urandom_range(0, 1) == 0)
            flags = flags | PG_DIRTY;
        if ($urandom_range(0, 1) == 0)
            flags = flags | PG_ON_NVME;
        return flags;
    endfunction

    // Present one input word and hold it until accepted. Returns at the falling edge
    // after acceptance without touching valid, so the next word can follow directly.
    // At the end of a burst, drop valid for a random gap first.
    task automatic send_item(input logic opens, input bytes_t request, input bytes_t host_free,
                             input logic present, input page_id_t ident, input bytes_t pbytes,
                             input logic [3:0] flags, input logic closes);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 24);
        end
        in_ch.valid            <= 1'b1;
        in_ch.plan_start       <= opens;
        in_ch.request_bytes    <= request;
        in_ch.host_avail_bytes <= host_free;
        in_ch.page_present     <= present;
        in_ch.page_ident       <= ident;
        in_ch.page_bytes       <= pbytes;
        in_ch.page_pinned      <= flags[3];
        in_ch.page_busy        <= flags[2];
        in_ch.page_dirty       <= flags[1];
        in_ch.page_on_nvme     <= flags[0];
        in_ch.plan_end         <= closes;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    // Stop sending and wait until every predicted word has drained, then give items
    // that produce no word time to clear the pipeline.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all three limits back to back, plus a write to the unmapped index,
    // which must change nothing.
    task automatic program_limits(input bytes_t capacity, input bytes_t held_back,
                                  input bytes_t in_use);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VRAM_CAPACITY;
        cfg_data  <= capacity;
        @(negedge clk);
        cfg_index <= CFG_VRAM_HELD_BACK;
        cfg_data  <= held_back;
        @(negedge clk);
        cfg_index <= CFG_VRAM_IN_USE;
        cfg_data  <= in_use;
        @(negedge clk);
        cfg_index <= CFG_UNMAPPED;
        cfg_data  <= rand_bytes(BYTE_COUNT_BITS);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One well-formed plan: a start word (sometimes carrying a page), up to eight
    // ranked pages, and an end word that is either its own word or rides on the last
    // page. About one plan in ten is cut off without its end word. Pages are up to four
    // bits narrower than the request so that some plans meet their shortfall and
    // others run out of candidates.
    task automatic run_random_plan(int scale);
        bytes_t request;
        bytes_t host_free;
        int     page_scale;
        int     pages;
        int     item_total;
        logic   lead_page;
        logic   split_end;
        logic   drop_end;
        request    = rand_bytes(scale);
        host_free  = rand_bytes(scale);
        page_scale = scale - $urandom_range(0, 4);
        pages      = $urandom_range(0, 8);
        lead_page  = ($urandom_range(0, 2) == 0);
        split_end  = 1'($urandom_range(0, 1));
        drop_end   = ($urandom_range(0, 9) == 0);
        item_total = 1 + pages + int'(split_end);
        for (int k = 0; k < item_total; k++)
        begin
            send_item(k == 0,
                      (k == 0) ? request : rand_bytes(BYTE_COUNT_BITS),
                      (k == 0) ? host_free : rand_bytes(BYTE_COUNT_BITS),
                      (k == 0) ? lead_page : (k <= pages),
                      page_id_t'($urandom), rand_bytes(page_scale), rand_page_flags(),
                      (k == item_total - 1) && !drop_end);
        end
    endtask

    initial
    begin : stimulus
        bytes_t capacity;
        bytes_t held_back;
        bytes_t in_use;
        int     scale;
        int     phase_goal;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_VRAM_CAPACITY;
        cfg_data               = '0;
        in_ch.valid            = 1'b0;
        in_ch.plan_start       = 1'b0;
        in_ch.request_bytes    = '0;
        in_ch.host_avail_bytes = '0;
        in_ch.page_present     = 1'b0;
        in_ch.page_ident       = '0;
        in_ch.page_bytes       = '0;
        in_ch.page_pinned      = 1'b0;
        in_ch.page_busy        = 1'b0;
        in_ch.page_dirty       = 1'b0;
        in_ch.page_on_nvme     = 1'b0;
        in_ch.plan_end         = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Straight out of reset, with no plan open: a page is handled against zero
        // state and gives nothing, an end word reports status, an empty word is ignored.
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0011, 48'd64, PG_DIRTY, 1'b0);
        send_item(1'b0, '0, '0, 1'b0, '0, '0, PG_NONE, 1'b1);
        send_item(1'b0, '0, '0, 1'b0, '0, '0, PG_NONE, 1'b0);
        settle();

        // Headroom = (1000 - 100) - 500 = 400.
        program_limits(48'd1000, 48'd100, 48'd500);

        // Shortfall 600, host budget 300; walk through every reason.
        send_item(1'b1, 48'd1000, 48'd300, 1'b0, '0, '0, PG_NONE, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0001, 48'd200, PG_NONE, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0002, 48'd64, PG_PINNED, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0003, 48'd64, PG_BUSY, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0004, 48'd64, PG_PINNED | PG_BUSY, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0005, 48'd150, PG_DIRTY, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0006, 48'd120, PG_ON_NVME, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0007, 48'd110, PG_NONE, 1'b0);
        // A zero-byte page still gets a decision.
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0008, '0, PG_NONE, 1'b0);
        // Largest page and identifier, dirty wins over the NVMe copy; decision plus status.
        send_item(1'b0, '0, '0, 1'b1, IDENT_MAX, BYTES_MAX, PG_DIRTY | PG_ON_NVME, 1'b1);

        // Page riding on the start word, then pages after the shortfall is met.
        send_item(1'b1, 48'd450, BYTES_MAX, 1'b1, '0, 48'd30, PG_NONE, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_0009, 48'd25, PG_NONE, 1'b0);
        send_item(1'b0, '0, '0, 1'b1, 32'h0000_000A, 48'd10, PG_DIRTY, 1'b0);
        send_item(1'b0, '0, '0, 1'b0, '0, '0, PG_NONE, 1'b1);

        // Largest request with only a pinned page: budget error.
        send_item(1'b1, BYTES_MAX, '0, 1'b1, 32'h0000_000B, 48'd4, PG_PINNED, 1'b1);
        // Request exactly at headroom: satisfied with no decision.
        send_item(1'b1, 48'd400, '0, 1'b1, 32'h0000_000C, 48'd5, PG_DIRTY, 1'b1);
        // One byte over headroom with no host budget: clean drop closes it.
        send_item(1'b1, 48'd401, '0, 1'b1, 32'h0000_000D, 48'd1, PG_ON_NVME, 1'b1);
        settle();

        // Random phases, each under its own set of limits.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    // All of capacity free: every request fits.
                    scale     = BYTE_COUNT_BITS;
                    capacity  = BYTES_MAX;
                    held_back = '0;
                    in_use    = '0;
                end
                1:
                begin
                    // Reserve above capacity: usable floors at zero.
                    scale     = 20;
                    capacity  = '0;
                    held_back = BYTES_MAX;
                    in_use    = '0;
                end
                2:
                begin
                    scale     = BYTE_COUNT_BITS;
                    capacity  = BYTES_MAX;
                    held_back = BYTES_MAX;
                    in_use    = BYTES_MAX;
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       scale = 12;
                        1:       scale = 16;
                        2:       scale = 24;
                        3:       scale = 32;
                        default: scale = BYTE_COUNT_BITS;
                    endcase
                    capacity  = rand_bytes(scale);
                    held_back = rand_bytes(scale - 2);
                    in_use    = rand_bytes(scale);
                end
            endcase
            program_limits(capacity, held_back, in_use);

            // Mostly plans; about one pick in ten is a single noise word with every field random.
            phase_goal = words_sent + ITEMS_PER_PHASE;
            while (words_sent < phase_goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(1'($urandom_range(0, 1)), rand_bytes(BYTE_COUNT_BITS),
                              rand_bytes(BYTE_COUNT_BITS), 1'($urandom_range(0, 1)),
                              page_id_t'($urandom), rand_bytes(BYTE_COUNT_BITS),
                              4'($urandom), 1'($urandom_range(0, 1)));
                else
                    run_random_plan(scale);
            end
            settle();
        end

        if (failures == 0 && words_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
